### hdl/flas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_pkg
// Shared constants for the flash linear address splitter.
// ---------------------------------------------------------------------------
package flas_pkg;

	localparam int ADDR_WIDTH_DEF = 40;

	// register widths
	localparam int PPB_W = 11;
	localparam int BPP_W = 17;
	localparam int PPD_W = 5;
	localparam int DPP_W = 5;
	localparam int PKG_W = 9;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_BLOCK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_PLANE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANES_PER_DIE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIES_PER_PACKAGE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PACKAGES_PER_DRIVE = 3'd4;

	// reset values
	localparam logic [PPB_W-1:0] PPB_RST = 11'd64;
	localparam logic [BPP_W-1:0] BPP_RST = 17'd2048;
	localparam logic [PPD_W-1:0] PPD_RST = 5'd1;
	localparam logic [DPP_W-1:0] DPP_RST = 5'd1;
	localparam logic [PKG_W-1:0] PKG_RST = 9'd1;

	// largest usable sizes
	localparam logic [PPB_W-1:0] PPB_MAX = 11'd1024;
	localparam logic [BPP_W-1:0] BPP_MAX = 17'd65536;
	localparam logic [PPD_W-1:0] PPD_MAX = 5'd16;
	localparam logic [DPP_W-1:0] DPP_MAX = 5'd16;
	localparam logic [PKG_W-1:0] PKG_MAX = 9'd256;

	// restoring steps done in one pipeline stage
	localparam int STEPS_PER_STAGE = 4;

endpackage

`default_nettype wire

### hdl/flas_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_in_if
// Linear page address channel.
// ---------------------------------------------------------------------------
interface flas_in_if #(
	parameter int ADDR_WIDTH = flas_pkg::ADDR_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [ADDR_WIDTH-1:0] linear_page;

	modport source (output valid, output linear_page, input ready);
	modport sink   (input valid, input linear_page, output ready);
endinterface

`default_nettype wire

### hdl/flas_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_out_if
// Flash coordinate channel.
// ---------------------------------------------------------------------------
interface flas_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  package_index;
	logic [3:0]  die_index;
	logic [3:0]  plane_index;
	logic [15:0] block_index;
	logic [9:0]  page_index;

	modport source (output valid, output package_index, output die_index,
		output plane_index, output block_index, output page_index, input ready);
	modport sink   (input valid, input package_index, input die_index,
		input plane_index, input block_index, input page_index, output ready);
endinterface

`default_nettype wire

### hdl/flas_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_cfg_if
// Register write channel.
// ---------------------------------------------------------------------------
interface flas_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [flas_pkg::CFG_IDX_W-1:0]  index;
	logic [flas_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/flash_linear_address_splitter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flash_linear_address_splitter_top
// Splits a linear page address into package/die/plane/block/page.
// ---------------------------------------------------------------------------
//  channel    role    payload
//  addr_in    sink    linear_page
//  coord_out  source  package_index, die_index, plane_index, block_index,
//                     page_index
//  cfg        sink    index, data (geometry register writes)
//
//  Five pipelined restoring dividers in a chain, four quotient bits per
//  stage; one transfer accepted every cycle while coord_out is not
//  stalled. The last divider stage is the output register. A stall on
//  coord_out freezes the whole pipeline at once, so addr_in.ready is low
//  only while a result waits untaken. Reset clears the valid bits and
//  loads the geometry defaults.
// ---------------------------------------------------------------------------
module flash_linear_address_splitter_top #(
	parameter int ADDR_WIDTH = flas_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	flas_in_if.sink   addr_in,
	flas_out_if.source coord_out,
	flas_cfg_if.sink  cfg
);
	localparam int BW  = flas_pkg::PPB_W;
	localparam int KW  = flas_pkg::BPP_W;
	localparam int LW  = flas_pkg::PPD_W;
	localparam int DW  = flas_pkg::DPP_W;
	localparam int GW  = flas_pkg::PKG_W;

	logic [BW-1:0] ppb_eff;
	logic [KW-1:0] bpp_eff;
	logic [LW-1:0] ppd_eff;
	logic [DW-1:0] dpp_eff;
	logic [GW-1:0] pkg_eff;

	// advance the whole pipeline unless a finished result is held back
	logic adv;
	assign adv           = !coord_out.valid || coord_out.ready;
	assign addr_in.ready = adv;

	flas_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ppb_eff (ppb_eff),
		.bpp_eff (bpp_eff),
		.ppd_eff (ppd_eff),
		.dpp_eff (dpp_eff),
		.pkg_eff (pkg_eff)
	);

	// page split
	logic                  v1;
	logic [ADDR_WIDTH-1:0] q1;
	logic [BW-1:0]         r1;
	flas_div #(.NW(ADDR_WIDTH), .DW(BW), .PW(1)) u_div_page (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(addr_in.valid), .in_num(addr_in.linear_page),
		.in_den(ppb_eff), .in_side(1'b0),
		.out_valid(v1), .out_quo(q1), .out_rem(r1), .out_side()
	);

	// block split, carry page coordinate
	localparam int P2 = 10;
	logic                  v2;
	logic [ADDR_WIDTH-1:0] q2;
	logic [KW-1:0]         r2;
	logic [P2-1:0]         s2;
	flas_div #(.NW(ADDR_WIDTH), .DW(KW), .PW(P2)) u_div_block (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v1), .in_num(q1), .in_den(bpp_eff), .in_side(r1[9:0]),
		.out_valid(v2), .out_quo(q2), .out_rem(r2), .out_side(s2)
	);

	// plane split
	localparam int P3 = P2 + 16;
	logic                  v3;
	logic [ADDR_WIDTH-1:0] q3;
	logic [LW-1:0]         r3;
	logic [P3-1:0]         s3;
	flas_div #(.NW(ADDR_WIDTH), .DW(LW), .PW(P3)) u_div_plane (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v2), .in_num(q2), .in_den(ppd_eff), .in_side({r2[15:0], s2}),
		.out_valid(v3), .out_quo(q3), .out_rem(r3), .out_side(s3)
	);

	// die split
	localparam int P4 = P3 + 4;
	logic                  v4;
	logic [ADDR_WIDTH-1:0] q4;
	logic [DW-1:0]         r4;
	logic [P4-1:0]         s4;
	flas_div #(.NW(ADDR_WIDTH), .DW(DW), .PW(P4)) u_div_die (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v3), .in_num(q3), .in_den(dpp_eff), .in_side({r3[3:0], s3}),
		.out_valid(v4), .out_quo(q4), .out_rem(r4), .out_side(s4)
	);

	// package split; higher quotient dropped
	localparam int P5 = P4 + 4;
	logic          v5;
	logic [GW-1:0] r5;
	logic [P5-1:0] s5;
	flas_div #(.NW(ADDR_WIDTH), .DW(GW), .PW(P5)) u_div_pkg (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(v4), .in_num(q4), .in_den(pkg_eff), .in_side({r4[3:0], s4}),
		.out_valid(v5), .out_quo(), .out_rem(r5), .out_side(s5)
	);

	assign coord_out.valid         = v5;
	assign coord_out.package_index = r5[7:0];
	assign coord_out.die_index     = s5[P5-1 -: 4];
	assign coord_out.plane_index   = s5[P4-1 -: 4];
	assign coord_out.block_index   = s5[P3-1 -: 16];
	assign coord_out.page_index    = s5[P2-1:0];

`ifndef ASSERT_OFF
	a_ready_follows_stall : assert property (@(posedge clk) disable iff (!arst_n)
		addr_in.ready == (!coord_out.valid || coord_out.ready))
		else $error("input ready does not follow output stall");

	a_page_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		coord_out.valid |-> ({1'b0, coord_out.page_index} < ppb_eff))
		else $error("page coordinate not below pages per block");

	a_pkg_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		coord_out.valid |-> ({1'b0, coord_out.package_index} < pkg_eff))
		else $error("package coordinate not below package count");
`endif

endmodule

`default_nettype wire

### hdl/flas_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_div
// Pipelined restoring divider, SPS quotient bits per stage, with side data.
// ---------------------------------------------------------------------------
module flas_div #(
	parameter int NW  = flas_pkg::ADDR_WIDTH_DEF,
	parameter int DW  = flas_pkg::PPB_W,
	parameter int PW  = 1,
	parameter int SPS = flas_pkg::STEPS_PER_STAGE
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [PW-1:0] in_side,
	output logic               out_valid,
	output logic [NW-1:0]      out_quo,
	output logic [DW-1:0]      out_rem,
	output logic [PW-1:0]      out_side
);
	localparam int NSTG = (NW + SPS - 1) / SPS;
	localparam int NP   = NSTG * SPS;

	// work word: unconsumed dividend bits at the top, quotient bits at the bottom
	logic          vld_s  [0:NSTG];
	logic [NP-1:0] work_s [0:NSTG];
	logic [DW-1:0] rem_s  [0:NSTG];
	logic [PW-1:0] side_s [0:NSTG];

	assign vld_s[0]  = in_valid;
	assign work_s[0] = NP'(in_num);
	assign rem_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar g = 1; g <= NSTG; g++) begin : g_stg
		logic [NP-1:0] w_nx;
		logic [DW-1:0] r_nx;

		always_comb begin
			logic [DW:0] t;
			w_nx = work_s[g-1];
			r_nx = rem_s[g-1];
			for (int i = 0; i < SPS; i++) begin
				t    = {r_nx, w_nx[NP-1]};
				w_nx = {w_nx[NP-2:0], 1'b0};
				if (t >= {1'b0, in_den}) begin
					t       = t - {1'b0, in_den};
					w_nx[0] = 1'b1;
				end
				r_nx = t[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= vld_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				work_s[g] <= w_nx;
				rem_s[g]  <= r_nx;
				side_s[g] <= side_s[g-1];
			end
		end
	end

	assign out_valid = vld_s[NSTG];
	assign out_quo   = work_s[NSTG][NW-1:0];
	assign out_rem   = rem_s[NSTG];
	assign out_side  = side_s[NSTG];

endmodule

`default_nettype wire

### hdl/flas_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flas_cfg_regs
// Geometry registers with zero and over-range sizes clamped to usable values.
// ---------------------------------------------------------------------------
module flas_cfg_regs (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	flas_cfg_if.sink                      cfg,
	output logic [flas_pkg::PPB_W-1:0]    ppb_eff,
	output logic [flas_pkg::BPP_W-1:0]    bpp_eff,
	output logic [flas_pkg::PPD_W-1:0]    ppd_eff,
	output logic [flas_pkg::DPP_W-1:0]    dpp_eff,
	output logic [flas_pkg::PKG_W-1:0]    pkg_eff
);
	logic [flas_pkg::PPB_W-1:0] ppb_q;
	logic [flas_pkg::BPP_W-1:0] bpp_q;
	logic [flas_pkg::PPD_W-1:0] ppd_q;
	logic [flas_pkg::DPP_W-1:0] dpp_q;
	logic [flas_pkg::PKG_W-1:0] pkg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppb_q <= flas_pkg::PPB_RST;
			bpp_q <= flas_pkg::BPP_RST;
			ppd_q <= flas_pkg::PPD_RST;
			dpp_q <= flas_pkg::DPP_RST;
			pkg_q <= flas_pkg::PKG_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				flas_pkg::REG_PAGES_PER_BLOCK:    ppb_q <= cfg.data[flas_pkg::PPB_W-1:0];
				flas_pkg::REG_BLOCKS_PER_PLANE:   bpp_q <= cfg.data[flas_pkg::BPP_W-1:0];
				flas_pkg::REG_PLANES_PER_DIE:     ppd_q <= cfg.data[flas_pkg::PPD_W-1:0];
				flas_pkg::REG_DIES_PER_PACKAGE:   dpp_q <= cfg.data[flas_pkg::DPP_W-1:0];
				flas_pkg::REG_PACKAGES_PER_DRIVE: pkg_q <= cfg.data[flas_pkg::PKG_W-1:0];
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// zero acts as one, over-range acts as the maximum
	assign ppb_eff = (ppb_q == '0) ? flas_pkg::PPB_W'(1) :
		(ppb_q > flas_pkg::PPB_MAX) ? flas_pkg::PPB_MAX : ppb_q;
	assign bpp_eff = (bpp_q == '0) ? flas_pkg::BPP_W'(1) :
		(bpp_q > flas_pkg::BPP_MAX) ? flas_pkg::BPP_MAX : bpp_q;
	assign ppd_eff = (ppd_q == '0) ? flas_pkg::PPD_W'(1) :
		(ppd_q > flas_pkg::PPD_MAX) ? flas_pkg::PPD_MAX : ppd_q;
	assign dpp_eff = (dpp_q == '0) ? flas_pkg::DPP_W'(1) :
		(dpp_q > flas_pkg::DPP_MAX) ? flas_pkg::DPP_MAX : dpp_q;
	assign pkg_eff = (pkg_q == '0) ? flas_pkg::PKG_W'(1) :
		(pkg_q > flas_pkg::PKG_MAX) ? flas_pkg::PKG_MAX : pkg_q;

endmodule

`default_nettype wire

### sim/flash_linear_address_splitter_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flash_linear_address_splitter_top_tb
// Checks the address splitter against an in-bench mixed-radix predictor over
// several geometries, with random gaps on both channels and a long hold-off.
// ---------------------------------------------------------------------------
module flash_linear_address_splitter_top_tb;

	localparam int AW      = flas_pkg::ADDR_WIDTH_DEF;
	localparam int LATENCY = 5 * ((AW + flas_pkg::STEPS_PER_STAGE - 1) /
		flas_pkg::STEPS_PER_STAGE);

	typedef struct packed {
		logic [7:0]  package_index;
		logic [3:0]  die_index;
		logic [3:0]  plane_index;
		logic [15:0] block_index;
		logic [9:0]  page_index;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	flas_in_if #(.ADDR_WIDTH(AW)) addr_in();
	flas_out_if coord_out();
	flas_cfg_if cfg();

	flash_linear_address_splitter_top #(.ADDR_WIDTH(AW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.addr_in(addr_in), .coord_out(coord_out), .cfg(cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// geometry copy held by the predictor
	logic [flas_pkg::PPB_W-1:0] geo_ppb = flas_pkg::PPB_RST;
	logic [flas_pkg::BPP_W-1:0] geo_bpp = flas_pkg::BPP_RST;
	logic [flas_pkg::PPD_W-1:0] geo_ppd = flas_pkg::PPD_RST;
	logic [flas_pkg::DPP_W-1:0] geo_dpp = flas_pkg::DPP_RST;
	logic [flas_pkg::PKG_W-1:0] geo_pkg = flas_pkg::PKG_RST;

	logic [AW-1:0] page_queue[$];
	coord_t        coord_queue[$];
	int            n_errors = 0;
	int            n_checked = 0;
	int            n_sent = 0;
	int            send_wait = 0;
	int            recv_wait = 0;
	int            hold_cycles = 0;
	bit            hold_req = 1'b0;

	// Clamp a size register to its usable range: zero acts as one, over-range acts as hi.
	function automatic longint unsigned usable(longint unsigned v, longint unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic coord_t split_page(logic [AW-1:0] page);
		longint unsigned a;
		longint unsigned s;
		coord_t c;
		a = page;
		s = usable(geo_ppb, flas_pkg::PPB_MAX);
		c.page_index = 10'(a % s);
		a = a / s;
		s = usable(geo_bpp, flas_pkg::BPP_MAX);
		c.block_index = 16'(a % s);
		a = a / s;
		s = usable(geo_ppd, flas_pkg::PPD_MAX);
		c.plane_index = 4'(a % s);
		a = a / s;
		s = usable(geo_dpp, flas_pkg::DPP_MAX);
		c.die_index = 4'(a % s);
		a = a / s;
		s = usable(geo_pkg, flas_pkg::PKG_MAX);
		c.package_index = 8'(a % s);
		return c;
	endfunction

	task automatic report(string what);
		n_errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Driver: offer queued pages with random gaps; predict on each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_in.valid <= 1'b0;
			addr_in.linear_page <= '0;
			send_wait <= 0;
		end else begin
			if (addr_in.valid && addr_in.ready) begin
				coord_queue.push_back(split_page(addr_in.linear_page));
				n_sent++;
			end
			if (!addr_in.valid || addr_in.ready) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
					addr_in.valid <= 1'b0;
				end else if (page_queue.size() > 0) begin
					addr_in.valid <= 1'b1;
					addr_in.linear_page <= page_queue.pop_front();
					send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				end else begin
					addr_in.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		coord_t exp_c;
		coord_t got_c;
		if (!arst_n) begin
			coord_out.ready <= 1'b0;
			recv_wait <= 0;
			hold_cycles <= 0;
		end else begin
			if (coord_out.valid && coord_out.ready) begin
				got_c = '{coord_out.package_index, coord_out.die_index,
					coord_out.plane_index, coord_out.block_index, coord_out.page_index};
				if (coord_queue.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					exp_c = coord_queue.pop_front();
					n_checked++;
					if (got_c.package_index != exp_c.package_index)
						report($sformatf("package %0d exp %0d",
							got_c.package_index, exp_c.package_index));
					if (got_c.die_index != exp_c.die_index)
						report($sformatf("die %0d exp %0d",
							got_c.die_index, exp_c.die_index));
					if (got_c.plane_index != exp_c.plane_index)
						report($sformatf("plane %0d exp %0d",
							got_c.plane_index, exp_c.plane_index));
					if (got_c.block_index != exp_c.block_index)
						report($sformatf("block %0d exp %0d",
							got_c.block_index, exp_c.block_index));
					if (got_c.page_index != exp_c.page_index)
						report($sformatf("page %0d exp %0d",
							got_c.page_index, exp_c.page_index));
				end
			end
			// long hold-off: keep ready low while the pipeline fills
			if (hold_req && hold_cycles == 0) begin
				hold_cycles <= 300;
				coord_out.ready <= 1'b0;
			end else if (hold_cycles > 1) begin
				hold_cycles <= hold_cycles - 1;
				coord_out.ready <= 1'b0;
			end else if (hold_cycles == 1) begin
				hold_cycles <= -1;
				coord_out.ready <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				coord_out.ready <= 1'b0;
			end else begin
				coord_out.ready <= 1'b1;
				recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
			end
		end
	end

	task automatic write_reg(logic [flas_pkg::CFG_IDX_W-1:0] idx,
		logic [flas_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			flas_pkg::REG_PAGES_PER_BLOCK:    geo_ppb = val[flas_pkg::PPB_W-1:0];
			flas_pkg::REG_BLOCKS_PER_PLANE:   geo_bpp = val[flas_pkg::BPP_W-1:0];
			flas_pkg::REG_PLANES_PER_DIE:     geo_ppd = val[flas_pkg::PPD_W-1:0];
			flas_pkg::REG_DIES_PER_PACKAGE:   geo_dpp = val[flas_pkg::DPP_W-1:0];
			flas_pkg::REG_PACKAGES_PER_DRIVE: geo_pkg = val[flas_pkg::PKG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(int ppb, int bpp, int ppd, int dpp, int pkg);
		write_reg(flas_pkg::REG_PAGES_PER_BLOCK, flas_pkg::CFG_DATA_W'(ppb));
		write_reg(flas_pkg::REG_BLOCKS_PER_PLANE, flas_pkg::CFG_DATA_W'(bpp));
		write_reg(flas_pkg::REG_PLANES_PER_DIE, flas_pkg::CFG_DATA_W'(ppd));
		write_reg(flas_pkg::REG_DIES_PER_PACKAGE, flas_pkg::CFG_DATA_W'(dpp));
		write_reg(flas_pkg::REG_PACKAGES_PER_DRIVE, flas_pkg::CFG_DATA_W'(pkg));
	endtask

	// Wait until every prediction has been matched, then let the pipe drain.
	task automatic drain();
		while (page_queue.size() > 0 || addr_in.valid || coord_queue.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [AW-1:0] rand_page();
		logic [AW-1:0] p;
		p = AW'({$urandom, $urandom});
		case ($urandom_range(0, 4))
			0: p = p & AW'(32'hFFFF);
			1: p = p & AW'(32'hFFFFFF);
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		int ppb_v, bpp_v, ppd_v, dpp_v, pkg_v;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		addr_in.valid = 1'b0;
		addr_in.linear_page = '0;
		coord_out.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset geometry, extremes of the address
		page_queue.push_back('0);
		page_queue.push_back('1);
		page_queue.push_back(AW'(63));
		page_queue.push_back(AW'(64));
		page_queue.push_back(AW'(64 * 2048));
		drain();
		// largest sizes, with out-of-range values that act as the maximum
		set_geometry(2047, 131071, 31, 31, 511);
		page_queue.push_back('1);
		page_queue.push_back('0);
		page_queue.push_back(AW'(40'hFF_FFFF_FFFF));
		page_queue.push_back(AW'(40'h80_0000_0000));
		drain();
		set_geometry(1024, 65536, 16, 16, 256);
		page_queue.push_back('1);
		page_queue.push_back(AW'(40'h12_3456_789A));
		drain();
		// zero sizes act as one; unknown register index changes nothing
		set_geometry(0, 0, 0, 0, 0);
		write_reg(flas_pkg::CFG_IDX_W'(5), '1);
		write_reg(flas_pkg::CFG_IDX_W'(7), '1);
		page_queue.push_back('1);
		page_queue.push_back(AW'(12345));
		drain();
		set_geometry(1, 1, 1, 1, 1);
		page_queue.push_back('1);
		page_queue.push_back(AW'(40'h55_AAAA_5555));
		drain();

		// random phases over random geometries; one phase holds off the sink
		for (int ph = 0; ph < 9; ph++) begin
			ppb_v = $urandom_range(0, 2047);
			bpp_v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) :
				$urandom_range(0, 70000);
			ppd_v = $urandom_range(0, 31);
			dpp_v = $urandom_range(0, 31);
			pkg_v = $urandom_range(0, 511);
			set_geometry(ppb_v, bpp_v, ppd_v, dpp_v, pkg_v);
			for (int k = 0; k < 50; k++)
				page_queue.push_back(rand_page());
			if (ph == 4)
				hold_req = 1'b1;
			drain();
			hold_req = 1'b0;
		end

		$display("Sent %0d addresses, checked %0d coordinate sets", n_sent, n_checked);
		$display("Geometries covered: reset, zero, maximum, oversize and random sizes");
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
